[src/mfu_pkg.sv]
// Shared types and constants of the message file unpacker.
package mfu_pkg;

	localparam logic [7:0] CARRIAGE_RETURN = 8'h0D;
	localparam logic [7:0] FIRST_PRINTABLE = 8'd32;
	// Control byte b maps to the letter b - 1 + 'A'.
	localparam logic [7:0] LETTER_OFFSET   = 8'd64;
	localparam logic [7:0] CH_QUOTE        = 8'h22;
	localparam logic [7:0] CH_NEWLINE      = 8'h0A;
	localparam logic [7:0] CH_AMP          = 8'h26;
	localparam logic [3:0] CH_DIGIT_HI     = 4'h3;

	localparam int RESULT_LIMIT = 10;
	localparam int CNT_W        = $clog2(RESULT_LIMIT);

	// Segments of output that one input byte can cause, in emission order.
	typedef struct packed {
		logic close1;
		logic num;
		logic amp;
		logic oq;
		logic copy;
		logic warn;
		logic close2;
	} plan_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_C1_Q,
		ST_C1_NL,
		ST_DIGIT,
		ST_NUM_Q,
		ST_AMP,
		ST_LETTER,
		ST_OPEN_Q,
		ST_COPY,
		ST_WARN,
		ST_C2_Q,
		ST_C2_NL
	} state_t;

	typedef enum logic [2:0] {
		SYM_QUOTE,
		SYM_NEWLINE,
		SYM_AMP,
		SYM_LETTER,
		SYM_DIGIT,
		SYM_BYTE,
		SYM_WARN
	} sym_t;

	typedef struct packed {
		logic accept;
		logic emit;
		logic last;
		sym_t sym;
	} cmd_t;

	typedef struct packed {
		plan_t plan;
		logic  out_free;
		logic  idx_zero;
		logic  limit_hit;
	} status_t;

endpackage

[src/mfu_ctrl.sv]
// Sequencer that walks the output segments of one request.
module mfu_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  mfu_pkg::status_t  status,
	output mfu_pkg::cmd_t     cmd
);

	mfu_pkg::state_t state_q, state_d, adv_state;
	mfu_pkg::plan_t  rem_q, rem_d, adv_rem;

	function automatic mfu_pkg::state_t first_seg(input mfu_pkg::plan_t p);
		mfu_pkg::state_t s;
		s = mfu_pkg::ST_IDLE;
		if (p.close1)      s = mfu_pkg::ST_C1_Q;
		else if (p.num)    s = mfu_pkg::ST_DIGIT;
		else if (p.amp)    s = mfu_pkg::ST_AMP;
		else if (p.oq)     s = mfu_pkg::ST_OPEN_Q;
		else if (p.copy)   s = mfu_pkg::ST_COPY;
		else if (p.warn)   s = mfu_pkg::ST_WARN;
		else if (p.close2) s = mfu_pkg::ST_C2_Q;
		return s;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mfu_pkg::ST_IDLE;
			rem_q   <= '0;
		end else begin
			state_q <= state_d;
			rem_q   <= rem_d;
		end
	end

	// Next state: where the sequence goes once the current character is sent.
	always_comb begin
		adv_rem   = rem_q;
		adv_state = state_q;
		unique case (state_q)
			mfu_pkg::ST_IDLE:   adv_state = mfu_pkg::ST_IDLE;
			mfu_pkg::ST_C1_Q:   adv_state = mfu_pkg::ST_C1_NL;
			mfu_pkg::ST_C1_NL: begin
				adv_rem.close1 = 1'b0;
				adv_state      = first_seg(adv_rem);
			end
			mfu_pkg::ST_DIGIT: begin
				if (status.idx_zero) adv_state = mfu_pkg::ST_NUM_Q;
			end
			mfu_pkg::ST_NUM_Q: begin
				adv_rem.num = 1'b0;
				adv_state   = first_seg(adv_rem);
			end
			mfu_pkg::ST_AMP:    adv_state = mfu_pkg::ST_LETTER;
			mfu_pkg::ST_LETTER: begin
				adv_rem.amp = 1'b0;
				adv_state   = first_seg(adv_rem);
			end
			mfu_pkg::ST_OPEN_Q: begin
				adv_rem.oq = 1'b0;
				adv_state  = first_seg(adv_rem);
			end
			mfu_pkg::ST_COPY: begin
				adv_rem.copy = 1'b0;
				adv_state    = first_seg(adv_rem);
			end
			mfu_pkg::ST_WARN: begin
				adv_rem.warn = 1'b0;
				adv_state    = first_seg(adv_rem);
			end
			mfu_pkg::ST_C2_Q:   adv_state = mfu_pkg::ST_C2_NL;
			mfu_pkg::ST_C2_NL: begin
				adv_rem.close2 = 1'b0;
				adv_state      = first_seg(adv_rem);
			end
			default:            adv_state = mfu_pkg::ST_IDLE;
		endcase
		// Characters past the result limit are dropped.
		if (status.limit_hit) begin
			adv_state = mfu_pkg::ST_IDLE;
			adv_rem   = '0;
		end

		state_d = state_q;
		rem_d   = rem_q;
		if (state_q == mfu_pkg::ST_IDLE) begin
			if (s_tvalid) begin
				state_d = first_seg(status.plan);
				rem_d   = status.plan;
			end
		end else if (status.out_free) begin
			state_d = adv_state;
			rem_d   = adv_rem;
		end
	end

	// Outputs: handshake and the character to load.
	always_comb begin
		s_tready   = (state_q == mfu_pkg::ST_IDLE);
		cmd.accept = s_tready && s_tvalid;
		cmd.emit   = (state_q != mfu_pkg::ST_IDLE) && status.out_free;
		cmd.last   = (adv_state == mfu_pkg::ST_IDLE);
		unique case (state_q)
			mfu_pkg::ST_C1_Q,
			mfu_pkg::ST_NUM_Q,
			mfu_pkg::ST_OPEN_Q,
			mfu_pkg::ST_C2_Q:   cmd.sym = mfu_pkg::SYM_QUOTE;
			mfu_pkg::ST_C1_NL,
			mfu_pkg::ST_C2_NL:  cmd.sym = mfu_pkg::SYM_NEWLINE;
			mfu_pkg::ST_DIGIT:  cmd.sym = mfu_pkg::SYM_DIGIT;
			mfu_pkg::ST_AMP:    cmd.sym = mfu_pkg::SYM_AMP;
			mfu_pkg::ST_LETTER: cmd.sym = mfu_pkg::SYM_LETTER;
			mfu_pkg::ST_WARN:   cmd.sym = mfu_pkg::SYM_WARN;
			default:            cmd.sym = mfu_pkg::SYM_BYTE;
		endcase
	end

endmodule

[src/mfu_datapath.sv]
// Section flags, message number counter, segment planning and output register.
module mfu_datapath #(
	parameter int NUMBER_DIGITS = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        s_tdata,
	input  logic              s_tlast,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,
	output logic [0:0]        m_tuser,
	output logic              m_tlast,
	input  mfu_pkg::cmd_t     cmd,
	output mfu_pkg::status_t  status
);

	localparam int IDX_W = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;

	logic                     err_q, mopen_q, lopen_q;
	logic                     err_d, mopen_d, lopen_d;
	logic [3:0]               digits_q [NUMBER_DIGITS];
	logic [3:0]               digits_inc [NUMBER_DIGITS];
	logic [7:0]               byte_q;
	logic                     fin_q, num_q;
	logic [IDX_W-1:0]         idx_q, top_idx;
	logic [mfu_pkg::CNT_W-1:0] cnt_q;
	logic                     m_tvalid_q, m_tlast_q, warn_q;
	logic [7:0]               m_tdata_q, char_d;
	mfu_pkg::plan_t           plan;
	logic                     lt32, is_cr, is_ctl, open_eff;

	// Plan the segments for the byte on the input and the flags it leaves.
	always_comb begin
		lt32     = s_tdata < mfu_pkg::FIRST_PRINTABLE;
		is_cr    = s_tdata == mfu_pkg::CARRIAGE_RETURN;
		is_ctl   = lt32 && (s_tdata != 8'd0);
		open_eff = mopen_q && !lt32;
		plan     = '0;
		err_d    = err_q;
		mopen_d  = mopen_q;
		lopen_d  = lopen_q;
		if (!err_q) begin
			plan.close1 = mopen_q && lt32;
			plan.copy   = open_eff;
			mopen_d     = open_eff;
			if (!open_eff) begin
				if (is_cr) begin
					err_d = 1'b1;
				end else if (is_ctl) begin
					plan.amp = 1'b1;
					plan.oq  = 1'b1;
					mopen_d  = 1'b1;
				end else begin
					plan.warn = 1'b1;
				end
			end
		end else begin
			plan.num    = !lopen_q;
			plan.close2 = is_cr;
			lopen_d     = !is_cr;
			plan.copy   = !lt32;
			plan.amp    = is_ctl && !is_cr;
		end
		if (s_tlast) begin
			plan.close2 = plan.close2 || mopen_d || lopen_d;
			err_d       = 1'b0;
			mopen_d     = 1'b0;
			lopen_d     = 1'b0;
		end
	end

	// Most significant nonzero digit; a value of zero still shows one digit.
	always_comb begin
		top_idx = '0;
		for (int i = 1; i < NUMBER_DIGITS; i++) begin
			if (digits_q[i] != 4'd0) top_idx = IDX_W'(i);
		end
	end

	// BCD increment, wrapping from all nines to zero.
	always_comb begin
		logic carry;
		carry = 1'b1;
		for (int i = 0; i < NUMBER_DIGITS; i++) begin
			digits_inc[i] = digits_q[i];
			if (carry) begin
				if (digits_q[i] >= 4'd9) begin
					digits_inc[i] = 4'd0;
				end else begin
					digits_inc[i] = digits_q[i] + 4'd1;
					carry         = 1'b0;
				end
			end
		end
	end

	always_comb begin
		case (cmd.sym)
			mfu_pkg::SYM_QUOTE:   char_d = mfu_pkg::CH_QUOTE;
			mfu_pkg::SYM_NEWLINE: char_d = mfu_pkg::CH_NEWLINE;
			mfu_pkg::SYM_AMP:     char_d = mfu_pkg::CH_AMP;
			mfu_pkg::SYM_LETTER:  char_d = byte_q + mfu_pkg::LETTER_OFFSET;
			mfu_pkg::SYM_DIGIT:   char_d = {mfu_pkg::CH_DIGIT_HI, digits_q[idx_q]};
			default:              char_d = byte_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q   <= 1'b0;
			mopen_q <= 1'b0;
			lopen_q <= 1'b0;
			for (int i = 0; i < NUMBER_DIGITS; i++) begin
				digits_q[i] <= (i == 0) ? 4'd1 : 4'd0;
			end
			fin_q      <= 1'b0;
			num_q      <= 1'b0;
			idx_q      <= '0;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				err_q   <= err_d;
				mopen_q <= mopen_d;
				lopen_q <= lopen_d;
				fin_q   <= s_tlast;
				num_q   <= plan.num;
				idx_q   <= top_idx;
				cnt_q   <= '0;
				// A request with no output finishes at once.
				if (plan == '0 && s_tlast) begin
					for (int i = 0; i < NUMBER_DIGITS; i++) begin
						digits_q[i] <= (i == 0) ? 4'd1 : 4'd0;
					end
				end
			end
			if (cmd.emit) begin
				cnt_q <= cnt_q + 1'b1;
				if (cmd.sym == mfu_pkg::SYM_DIGIT && idx_q != '0) idx_q <= idx_q - 1'b1;
				// The number is shown before it counts up.
				if (cmd.last) begin
					if (fin_q) begin
						for (int i = 0; i < NUMBER_DIGITS; i++) begin
							digits_q[i] <= (i == 0) ? 4'd1 : 4'd0;
						end
					end else if (num_q) begin
						digits_q <= digits_inc;
					end
				end
			end
			if (cmd.emit) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) byte_q <= s_tdata;
		if (cmd.emit) begin
			m_tdata_q <= char_d;
			warn_q    <= (cmd.sym == mfu_pkg::SYM_WARN);
			m_tlast_q <= cmd.last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = warn_q;
	assign m_tlast  = m_tlast_q;

	assign status.plan      = plan;
	assign status.out_free  = !m_tvalid_q || m_tready;
	assign status.idx_zero  = (idx_q == '0);
	assign status.limit_hit = (cnt_q == mfu_pkg::CNT_W'(mfu_pkg::RESULT_LIMIT - 1));

endmodule

[src/message_file_unpacker.sv]
// Top level of the message file unpacker.
//
//  channel  | dir | handshake          | tdata          | tuser    | tlast
//  ---------+-----+--------------------+----------------+----------+----------
//  s_       | in  | s_tvalid/s_tready  | data_byte      | -        | final_byte
//  m_       | out | m_tvalid/m_tready  | text_char      | warning  | run_end
//
// One byte is taken, then its 0 to 10 characters leave one per cycle, while the
// output is not stalled, from the output register; the sequencer sends them.
// A stalled output holds the sequencer; the input is ready only between bytes.
// Reset returns to the macro section with message number one.
module message_file_unpacker #(
	parameter int NUMBER_DIGITS = 5
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] data_byte
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] text_char
	output logic [0:0] m_tuser,   // [0] warning
	output logic       m_tlast
);

	mfu_pkg::cmd_t    cmd;
	mfu_pkg::status_t status;

	mfu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	mfu_datapath #(
		.NUMBER_DIGITS (NUMBER_DIGITS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cmd      (cmd),
		.status   (status)
	);

endmodule

[src/mfu_checker.sv]
// Port-level checks of the message file unpacker, bound to the top level.
module mfu_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tvalid,
	input logic       s_tready,
	input logic [7:0] s_tdata,
	input logic       s_tlast,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic [0:0] m_tuser,
	input logic       m_tlast
);

	// A stalled result keeps its value.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled result changed");

	// A warning is always the last result of its request.
	a_warn_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tlast)
		else $error("warning not last in run");

	// Only a zero byte or a printable byte can raise a warning.
	a_warn_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (m_tdata == 8'd0) || (m_tdata >= 8'd32))
		else $error("warning on a control byte");

	// No new request is taken while the current one still has results to send.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> !s_tready)
		else $error("input ready in the middle of a run");

endmodule

bind message_file_unpacker mfu_checker u_mfu_checker (.*);
